[rtl/bbsym_pkg.sv]
// ----------------------------------------------------------------------------
// bbsym_pkg
// Operation codes and the controller/datapath link types of the bit board unit.
// ----------------------------------------------------------------------------
package bbsym_pkg;

    typedef logic [3:0] t_op;

    localparam t_op OP_LOAD   = 4'd0;
    localparam t_op OP_TEST   = 4'd1;
    localparam t_op OP_WRITE  = 4'd2;
    localparam t_op OP_BSWAP  = 4'd3;
    localparam t_op OP_BREV   = 4'd4;
    localparam t_op OP_TMAIN  = 4'd5;
    localparam t_op OP_TANTI  = 4'd6;
    localparam t_op OP_LIST   = 4'd7;
    localparam t_op OP_READ   = 4'd8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;       // apply the accepted item and load its single result
        logic scan_load;  // start a listing: copy the board into the scan word
        logic scan_step;  // emit the lowest remaining square
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_is_list;
        logic board_zero;
        logic out_free;
        logic scan_last;
    } t_sts;

endpackage

[rtl/bbsym_in_if.sv]
// ----------------------------------------------------------------------------
// bbsym_in_if
// Input item channel: one operation on the bit board.
// ----------------------------------------------------------------------------
interface bbsym_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [5:0]  bit_index;
    logic        bit_value;
    logic [63:0] board_value;

    modport source (
        output valid, operation, bit_index, bit_value, board_value,
        input  ready
    );
    modport sink (
        input  valid, operation, bit_index, bit_value, board_value,
        output ready
    );
endinterface

[rtl/bbsym_out_if.sv]
// ----------------------------------------------------------------------------
// bbsym_out_if
// Result item channel: board after the operation plus test and listing data.
// ----------------------------------------------------------------------------
interface bbsym_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] board_out;
    logic        bit_result;
    logic [5:0]  position;
    logic        position_valid;
    logic        last;

    modport source (
        output valid, board_out, bit_result, position, position_valid, last,
        input  ready
    );
    modport sink (
        input  valid, board_out, bit_result, position, position_valid, last,
        output ready
    );
endinterface

[rtl/bitboard_symmetry_and_bitscan_unit.sv]
// A single result is valid the cycle after its item is accepted; a listing first
//   loads the scan word, then emits one square per cycle while the result slot is free.
// One item is taken per cycle while results drain each cycle; no item is taken while a
//   listing runs, and a list on an empty board gives a single result like other items.
// Reset: synchronous, active low; clears the board, the scan word and the result valid.
// ----------------------------------------------------------------------------
// bitboard_symmetry_and_bitscan_unit
// 8x8 bit board register with load, bit test/write, mirror and transpose
// transforms, read, and an ascending listing of the set squares.
// ----------------------------------------------------------------------------
module bitboard_symmetry_and_bitscan_unit import bbsym_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bbsym_in_if.sink    i_item,
    bbsym_out_if.source o_result
);

    // Command and status links between the sequencer and the datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // The controller decides when an item enters and steps the listing;
    // an item is taken only while no listing runs and the result slot
    // is empty or being emptied in the same cycle.
    bbsym_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_sts      (w_sts),
        .o_in_ready (i_item.ready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the board, applies the transforms as pure wiring,
    // isolates the lowest remaining square with a wide add and subtract per step, and
    // parks each result in an output register that frees the input side.
    bbsym_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_operation      (i_item.operation),
        .i_bit_index      (i_item.bit_index),
        .i_bit_value      (i_item.bit_value),
        .i_board_value    (i_item.board_value),
        .i_out_ready      (o_result.ready),
        .o_sts            (w_sts),
        .o_out_valid      (o_result.valid),
        .o_board_out      (o_result.board_out),
        .o_bit_result     (o_result.bit_result),
        .o_position       (o_result.position),
        .o_position_valid (o_result.position_valid),
        .o_last           (o_result.last)
    );

endmodule

[rtl/bbsym_ctrl.sv]
// ----------------------------------------------------------------------------
// bbsym_ctrl
// Controller: accepts items and sequences the set-square listing.
// ----------------------------------------------------------------------------
module bbsym_ctrl import bbsym_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    if (i_sts.op_is_list && !i_sts.board_zero) begin
                        o_cmd.scan_load = 1'b1;
                        n_state         = ST_SCAN;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.out_free) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.exec, o_cmd.scan_load, o_cmd.scan_step}))
        else $error("more than one datapath command at once");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan_step && i_sts.scan_last) |=> (r_state == ST_IDLE))
        else $error("listing did not end after its last square");

    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SCAN) |-> $past(o_cmd.scan_load))
        else $error("listing entered without a scan load");
`endif

endmodule

[rtl/bbsym_dp.sv]
// ----------------------------------------------------------------------------
// bbsym_dp
// Datapath: board and scan registers, transforms, bit scan and result register.
// ----------------------------------------------------------------------------
module bbsym_dp import bbsym_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [3:0]  i_operation,
    input  logic [5:0]  i_bit_index,
    input  logic        i_bit_value,
    input  logic [63:0] i_board_value,
    input  logic        i_out_ready,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output logic [63:0] o_board_out,
    output logic        o_bit_result,
    output logic [5:0]  o_position,
    output logic        o_position_valid,
    output logic        o_last
);

    function automatic logic [63:0] swap_bytes(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] reverse_in_bytes(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                r[8*i + j] = x[8*i + 7 - j];
            end
        end
        return r;
    endfunction

    // (rank, file) -> (file, rank)
    function automatic logic [63:0] transpose_main(input logic [63:0] x);
        logic [63:0] r;
        for (int rk = 0; rk < 8; rk++) begin
            for (int fl = 0; fl < 8; fl++) begin
                r[8*fl + rk] = x[8*rk + fl];
            end
        end
        return r;
    endfunction

    // (rank, file) -> (7 - file, 7 - rank)
    function automatic logic [63:0] transpose_anti(input logic [63:0] x);
        logic [63:0] r;
        for (int rk = 0; rk < 8; rk++) begin
            for (int fl = 0; fl < 8; fl++) begin
                r[8*(7-fl) + (7-rk)] = x[8*rk + fl];
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] encode_onehot(input logic [63:0] oh);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (oh[i]) begin
                p = p | 6'(i);
            end
        end
        return p;
    endfunction

    logic [63:0] r_board;
    logic [63:0] n_board;
    logic [63:0] r_scan;
    logic [63:0] n_scan;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [63:0] r_out_board;
    logic        r_out_bit;
    logic [5:0]  r_out_pos;
    logic        r_out_pv;
    logic        r_out_last;

    logic [63:0] w_exec_board;
    logic [63:0] w_lowbit;
    logic [63:0] w_scan_clr;
    logic        w_out_free;

    always_comb begin
        w_exec_board = r_board;
        case (i_operation)
            OP_LOAD:  w_exec_board = i_board_value;
            OP_WRITE: w_exec_board[i_bit_index] = i_bit_value;
            OP_BSWAP: w_exec_board = swap_bytes(r_board);
            OP_BREV:  w_exec_board = reverse_in_bytes(r_board);
            OP_TMAIN: w_exec_board = transpose_main(r_board);
            OP_TANTI: w_exec_board = transpose_anti(r_board);
            default:  w_exec_board = r_board;
        endcase
    end

    // Isolate and clear the lowest remaining square
    assign w_lowbit   = r_scan & (~r_scan + 64'd1);
    assign w_scan_clr = r_scan & (r_scan - 64'd1);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_sts.op_is_list = (i_operation == OP_LIST);
    assign o_sts.board_zero = (r_board == 64'd0);
    assign o_sts.out_free   = w_out_free;
    assign o_sts.scan_last  = (w_scan_clr == 64'd0);

    always_comb begin
        n_board = r_board;
        n_scan  = r_scan;
        if (i_cmd.exec) begin
            n_board = w_exec_board;
        end
        if (i_cmd.scan_load) begin
            n_scan = r_board;
        end else if (i_cmd.scan_step) begin
            n_scan = w_scan_clr;
        end
        n_out_valid = (r_out_valid && !i_out_ready) || i_cmd.exec || i_cmd.scan_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_board     <= n_board;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_board <= w_exec_board;
            r_out_bit   <= (i_operation == OP_TEST) ? r_board[i_bit_index] : 1'b0;
            r_out_pos   <= '0;
            r_out_pv    <= 1'b0;
            r_out_last  <= 1'b1;
        end else if (i_cmd.scan_step) begin
            r_out_board <= r_board;
            r_out_bit   <= 1'b0;
            r_out_pos   <= encode_onehot(w_lowbit);
            r_out_pv    <= 1'b1;
            r_out_last  <= (w_scan_clr == 64'd0);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_board_out      = r_out_board;
    assign o_bit_result     = r_out_bit;
    assign o_position       = r_out_pos;
    assign o_position_valid = r_out_pv;
    assign o_last           = r_out_last;

`ifndef SYNTHESIS
    a_pos_is_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pv) |-> r_out_board[r_out_pos])
        else $error("listed square is not set on the board");

    a_step_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (r_scan != 64'd0))
        else $error("scan step with no remaining squares");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_pv) |-> r_out_last)
        else $error("non-listing result without last mark");
`endif

endmodule
